// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Widths, status codes and the command struct sent to the cell chain.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int TAG_W    = 32;
  localparam int STAT_W   = 2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic        [TAG_W-1:0] tag_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } spq_cmd_t;

endpackage

// ----- rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds a key and tag. On insert it keeps, takes the new entry, or takes its
// left neighbor; on remove it takes its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic     clk,
  input  spq_cmd_t cmd,
  input  key_t     new_key,
  input  tag_t     new_tag,
  input  logic     occupied,
  input  logic     left_ge,
  input  key_t     left_key,
  input  tag_t     left_tag,
  input  key_t     right_key,
  input  tag_t     right_tag,
  output logic     ge,
  output key_t     key,
  output tag_t     tag
);

  // new entry belongs here or further left
  assign ge = !occupied || (new_key <= key);

  always_ff @(posedge clk) begin
    if (cmd.ins && ge) begin
      if (left_ge) begin
        key <= left_key;
        tag <= left_tag;
      end else begin
        key <= new_key;
        tag <= new_tag;
      end
    end else if (cmd.rem) begin
      key <= right_key;
      tag <= right_tag;
    end
  end

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded min-priority queue as a chain of cells
// Entries sit sorted by signed key in a row of cells, minimum in cell 0.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries op, key_in, tag_in per beat:
// op 0 inserts key_in/tag_in ahead of equal keys, op 1 removes the minimum.
// Output channel (out_valid/out_ready) returns one beat per input beat with
// status (ok, empty on remove, full on insert), key_out/tag_out of the
// removed entry (zero otherwise) and item_count after the operation.
// Every cell compares the incoming key with its own in parallel and shifts
// by one slot, so an operation completes in the cycle it is accepted; the
// result is registered and appears in the next cycle. Throughput is one item
// per cycle while out_ready does not hold the result register.
// The result register holds a beat while out_ready is low; a new input beat
// is taken only when that register is empty or being drained.
// Reset clears the item count and the output valid; cell contents need no
// reset since only slots below the count are ever used.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              op,
  input  key_t              key_in,
  input  tag_t              tag_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] status,
  output key_t              key_out,
  output tag_t              tag_out,
  output logic [CNT_W-1:0]  item_count
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             is_full;
  logic             is_empty;
  spq_cmd_t         cmd;

  key_t             cell_key [CAPACITY];
  tag_t             cell_tag [CAPACITY];
  logic [CAPACITY-1:0] cell_ge;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_full  = (count == CNT_W'(CAPACITY));
  assign is_empty = (count == '0);
  assign cmd.ins  = accept && (op == OP_INSERT) && !is_full;
  assign cmd.rem  = accept && (op == OP_REMOVE) && !is_empty;

  always_comb begin
    count_next = count;
    if (cmd.ins) count_next = count + CNT_W'(1);
    else if (cmd.rem) count_next = count - CNT_W'(1);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t lk, rk;
    tag_t lt, rt;
    logic lg;
    if (i == 0) begin : g_first
      assign lk = key_in;
      assign lt = tag_in;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lk = cell_key[i-1];
      assign lt = cell_tag[i-1];
      assign lg = cell_ge[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rk = cell_key[i];
      assign rt = cell_tag[i];
    end else begin : g_inner
      assign rk = cell_key[i+1];
      assign rt = cell_tag[i+1];
    end
    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .new_key   (key_in),
      .new_tag   (tag_in),
      .occupied  (CNT_W'(i) < count),
      .left_ge   (lg),
      .left_key  (lk),
      .left_tag  (lt),
      .right_key (rk),
      .right_tag (rt),
      .ge        (cell_ge[i]),
      .key       (cell_key[i]),
      .tag       (cell_tag[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_count <= count_next;
      if (op == OP_INSERT) begin
        status  <= is_full ? ST_FULL : ST_OK;
        key_out <= '0;
        tag_out <= '0;
      end else if (is_empty) begin
        status  <= ST_EMPTY;
        key_out <= '0;
        tag_out <= '0;
      end else begin
        status  <= ST_OK;
        key_out <= cell_key[0];
        tag_out <= cell_tag[0];
      end
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for sorted_priority_queue
// Drives insert and remove-minimum beats with random gaps on both channels,
// keeps its own sorted copy of the queue and checks every result beat in
// order: status, removed key and tag, and item count.
// ----------------------------------------------------------------------------
module tb_top;
  import spq_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 10;
  localparam int LONG_HOLD   = 300;
  localparam int MIX_PHASES  = 10;
  localparam int MIX_BEATS   = 100;

  typedef struct {
    logic [STAT_W-1:0] status;
    key_t              key;
    tag_t              tag;
    logic [CNT_W-1:0]  count;
  } pq_result_t;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic              op         = OP_INSERT;
  key_t              key_in     = '0;
  tag_t              tag_in     = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic [STAT_W-1:0] status;
  key_t              key_out;
  tag_t              tag_out;
  logic [CNT_W-1:0]  item_count;

  key_t       sorted_keys [CAPACITY];
  tag_t       sorted_tags [CAPACITY];
  int         held        = 0;
  pq_result_t due_results [$];

  int err_cnt     = 0;
  int idle_cycles = 0;
  int tx_gap_max  = 4;
  int rx_gap_max  = 4;
  int rx_wait     = 0;
  int rx_hold     = 0;

  sorted_priority_queue i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .key_in    (key_in),
    .tag_in    (tag_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .key_out   (key_out),
    .tag_out   (tag_out),
    .item_count(item_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Sorted list, minimum first; an insert lands ahead of equal keys.
  function automatic pq_result_t apply_queue_op(logic o, key_t k, tag_t t);
    pq_result_t r;
    int         pos;
    int         i;
    r.status = ST_OK;
    r.key    = '0;
    r.tag    = '0;
    if (o == OP_INSERT) begin
      if (held >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held && k > sorted_keys[pos]) pos++;
        for (i = held; i > pos; i--) begin
          sorted_keys[i] = sorted_keys[i-1];
          sorted_tags[i] = sorted_tags[i-1];
        end
        sorted_keys[pos] = k;
        sorted_tags[pos] = t;
        held++;
      end
    end else begin
      if (held == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.key = sorted_keys[0];
        r.tag = sorted_tags[0];
        for (i = 1; i < held; i++) begin
          sorted_keys[i-1] = sorted_keys[i];
          sorted_tags[i-1] = sorted_tags[i];
        end
        held--;
      end
    end
    r.count = CNT_W'(held);
    return r;
  endfunction

  // Called and returns at a falling edge.
  task automatic send_beat(input logic o, input key_t k, input tag_t t);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    key_in   <= k;
    tag_in   <= t;
    do @(posedge clk); while (!in_ready);
    due_results.push_back(apply_queue_op(o, k, t));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
  endtask

  function automatic key_t rand_key();
    key_t k;
    case ($urandom_range(0, 3))
      0: k = key_t'($urandom);
      1: k = key_t'($urandom_range(0, 6)) - key_t'(3);
      2: begin
        case ($urandom_range(0, 3))
          0: k = 32'sh7FFF_FFFF;
          1: k = 32'sh8000_0000;
          2: k = 32'sh0000_0000;
          default: k = 32'shFFFF_FFFF;
        endcase
      end
      default: k = {16'($urandom_range(0, 255)) - 16'd128, 16'h0000};
    endcase
    return k;
  endfunction

  task automatic test_directed();
    tx_gap_max = 0;
    rx_gap_max = 0;
    send_beat(OP_REMOVE, '0, '0);
    send_beat(OP_INSERT, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    send_beat(OP_INSERT, 32'sh8000_0000, 32'h0000_0000);
    send_beat(OP_INSERT, 32'sh0000_0000, 32'h0000_0001);
    send_beat(OP_INSERT, 32'sh0001_0000, 32'h0000_000A);
    send_beat(OP_INSERT, 32'sh0001_0000, 32'h0000_000B);
    send_beat(OP_INSERT, 32'sh0001_0000, 32'h0000_000C);
    send_beat(OP_INSERT, 32'shFFFF_FFFF, 32'h5555_5555);
    send_beat(OP_INSERT, 32'sh8000_0001, 32'hAAAA_AAAA);
    tx_gap_max = 4;
    rx_gap_max = 4;
    repeat (9) send_beat(OP_REMOVE, key_t'($urandom), $urandom);
    send_beat(OP_REMOVE, '0, '0);
  endtask

  // Receiver holds off while the queue fills, so the input stalls.
  task automatic test_fill_overflow();
    tx_gap_max = 0;
    rx_hold    = LONG_HOLD;
    while (held < CAPACITY) send_beat(OP_INSERT, rand_key(), $urandom);
    repeat (6) send_beat(OP_INSERT, rand_key(), $urandom);
    tx_gap_max = 4;
    while (held > 0) send_beat(OP_REMOVE, '0, $urandom);
    repeat (2) send_beat(OP_REMOVE, key_t'($urandom), '0);
  endtask

  task automatic test_random_mix();
    int ins_pct [MIX_PHASES];
    int p;
    int n;
    ins_pct = '{80, 50, 25, 95, 60, 10, 90, 55, 40, 70};
    for (p = 0; p < MIX_PHASES; p++) begin
      tx_gap_max = (p % 3 == 0) ? 0 : 4;
      rx_gap_max = (p % 4 == 1) ? 0 : 4;
      for (n = 0; n < MIX_BEATS; n++) begin
        if ($urandom_range(0, 99) < ins_pct[p])
          send_beat(OP_INSERT, rand_key(), $urandom);
        else
          send_beat(OP_REMOVE, key_t'($urandom), $urandom);
      end
      if (p % 3 == 2) wait_drained();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_fill_overflow();
    test_random_mix();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0 && due_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Receiver: long hold-off first, then a random wait per beat.
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic flag_field(input string name, input logic [31:0] exp_v,
                            input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    pq_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected beat, expected none, actual status %h key %h tag %h count %0d",
                 $time, status, key_out, tag_out, item_count);
      end else begin
        exp_r = due_results.pop_front();
        flag_field("status", 32'(exp_r.status), 32'(status));
        flag_field("key_out", exp_r.key, key_out);
        flag_field("tag_out", exp_r.tag, tag_out);
        flag_field("item_count", 32'(exp_r.count), 32'(item_count));
      end
      rx_wait = $urandom_range(0, rx_gap_max);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule

// ----- sorted_priority_queue.f -----
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/sv/tb_top.sv
